>>> src/md5_message_digest_defines.svh
// Assertion macros used by the checker file.
`ifndef MD5_MESSAGE_DIGEST_DEFINES_SVH
`define MD5_MESSAGE_DIGEST_DEFINES_SVH
// Assert that a condition implies a consequence in the next cycle.
`define MD5_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("md5 check failed");
// Assert that a condition implies a consequence in the same cycle.
`define MD5_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("md5 check failed");
`endif

>>> src/md5_pkg.sv
// Package with MD5 constants, tables and the queue entry type.
`default_nettype none
package md5_pkg;
  localparam int unsigned QueueDepth = 4;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       has_byte;
    logic       end_of_message;
  } md5_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_ROUND,
    ST_FINAL,
    ST_EMIT
  } md5_state_t;

  localparam logic [31:0] InitA = 32'h67452301;
  localparam logic [31:0] InitB = 32'hefcdab89;
  localparam logic [31:0] InitC = 32'h98badcfe;
  localparam logic [31:0] InitD = 32'h10325476;

  function automatic logic [31:0] round_const(input logic [5:0] i);
    logic [31:0] k [64];
    k = '{
      32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee, 32'hf57c0faf, 32'h4787c62a,
      32'ha8304613, 32'hfd469501, 32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
      32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821, 32'hf61e2562, 32'hc040b340,
      32'h265e5a51, 32'he9b6c7aa, 32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
      32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed, 32'ha9e3e905, 32'hfcefa3f8,
      32'h676f02d9, 32'h8d2a4c8a, 32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
      32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70, 32'h289b7ec6, 32'heaa127fa,
      32'hd4ef3085, 32'h04881d05, 32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
      32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039, 32'h655b59c3, 32'h8f0ccc92,
      32'hffeff47d, 32'h85845dd1, 32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
      32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391};
    return k[i];
  endfunction

  function automatic logic [4:0] rot_amount(input logic [3:0] j);
    logic [4:0] r [16];
    r = '{5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9, 5'd14, 5'd20,
          5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21};
    return r[j];
  endfunction
endpackage
`default_nettype wire

>>> src/md5_message_digest.sv
// Top level of the MD5 digest engine: input queue and compression back end.
//   channel | direction | beat contents
//   s_axis  | in        | tdata: data_byte; tuser: has_byte; tlast: end_of_message
//   m_axis  | out       | tdata: digest_word; tuser: word_index; tlast: last_word
// A byte that leaves the buffer short of full and does not end the message
// is only stored. A full buffer runs a block, one MD5 round per cycle.
// End of message pads one byte per cycle, then runs one or two blocks and
// shows four digest beats. A four-entry queue accepts until full while the
// back end works. Reset is synchronous and returns the initial chain value.
`default_nettype none
module md5_message_digest #(
  parameter int unsigned QueueDepth = md5_pkg::QueueDepth
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // data_byte
  input  wire logic        s_axis_tuser,   // has_byte
  input  wire logic        s_axis_tlast,   // end_of_message
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [31:0]      m_axis_tdata,   // digest_word
  output logic [1:0]       m_axis_tuser,   // word_index
  output logic             m_axis_tlast    // last_word
);
  md5_pkg::md5_item_t in_item, q_item;
  logic q_full, q_empty, q_pop;

  assign in_item = '{data_byte: s_axis_tdata, has_byte: s_axis_tuser,
                     end_of_message: s_axis_tlast};
  assign s_axis_tready = !q_full;

  md5_queue #(.Depth(QueueDepth)) u_queue (
    .clk, .rst,
    .push(s_axis_tvalid), .push_item(in_item), .full(q_full),
    .pop(q_pop), .pop_item(q_item), .empty(q_empty)
  );

  md5_core u_core (
    .clk, .rst,
    .item(q_item), .item_valid(!q_empty), .item_pop(q_pop),
    .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
    .out_word(m_axis_tdata), .out_index(m_axis_tuser), .out_last(m_axis_tlast)
  );
endmodule
`default_nettype wire

>>> src/md5_queue.sv
// Short queue that parts the input side from the compression engine.
`default_nettype none
module md5_queue #(
  parameter int unsigned Depth = md5_pkg::QueueDepth
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               push,
  input  md5_pkg::md5_item_t      push_item,
  output logic                    full,
  input  wire logic               pop,
  output md5_pkg::md5_item_t      pop_item,
  output logic                    empty
);
  localparam int unsigned Aw = (Depth > 1) ? $clog2(Depth) : 1;
  md5_pkg::md5_item_t entries [Depth];
  logic [Aw-1:0] wr_ptr, rd_ptr;
  logic [Aw:0]   count;

  assign full     = (count == (Aw+1)'(Depth));
  assign empty    = (count == '0);
  assign pop_item = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push && !full) begin
      entries[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push && !full) begin
        wr_ptr <= (wr_ptr == Aw'(Depth - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop && !empty) begin
        rd_ptr <= (rd_ptr == Aw'(Depth - 1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + (Aw+1)'(push && !full) - (Aw+1)'(pop && !empty);
    end
  end
endmodule
`default_nettype wire

>>> src/md5_core.sv
// Back end: byte buffer, padding, one MD5 round per cycle and digest output.
`default_nettype none
module md5_core (
  input  wire logic               clk,
  input  wire logic               rst,
  input  md5_pkg::md5_item_t      item,
  input  wire logic               item_valid,
  output logic                    item_pop,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [31:0]             out_word,
  output logic [1:0]              out_index,
  output logic                    out_last
);
  md5_pkg::md5_state_t state, state_next;
  logic [31:0] buffer [16];
  logic [5:0]  byte_position;
  logic [63:0] bit_count, len;
  logic [31:0] ca, cb, cc, cd;
  logic [31:0] a, b, c, d;
  logic [5:0]  rnd;
  logic [1:0]  emit_index;
  logic        pad_first;
  logic        after_pad;
  logic        extra_block;
  logic [31:0] wreg;

  logic [3:0]  g;
  logic [5:0]  fetch_rnd;
  logic [31:0] f, sum, rot;
  logic [4:0]  s;
  logic [7:0]  pad_byte;
  logic        take_byte, round_last;

  assign fetch_rnd = (state == md5_pkg::ST_ROUND) ? rnd + 6'd1 : 6'd0;

  // Word fetch for the next round, registered before use.
  always_comb begin
    unique case (fetch_rnd[5:4])
      2'd0:    g = fetch_rnd[3:0];
      2'd1:    g = 4'(5 * fetch_rnd[3:0] + 1);
      2'd2:    g = 4'(3 * fetch_rnd[3:0] + 5);
      default: g = 4'(7 * fetch_rnd[3:0]);
    endcase
  end

  always_comb begin
    unique case (rnd[5:4])
      2'd0:    f = (b & c) | (~b & d);
      2'd1:    f = (b & d) | (c & ~d);
      2'd2:    f = b ^ c ^ d;
      default: f = c ^ (b | ~d);
    endcase
    s   = md5_pkg::rot_amount({rnd[5:4], rnd[1:0]});
    sum = a + f + md5_pkg::round_const(rnd) + wreg;
    rot = (sum << s) | (sum >> (6'd32 - {1'b0, s}));
  end

  always_comb begin
    if (pad_first) begin
      pad_byte = 8'h80;
    end else if (byte_position >= 6'd56 && !extra_block) begin
      pad_byte = len[8*byte_position[2:0] +: 8];
    end else begin
      pad_byte = 8'h00;
    end
  end

  assign round_last = (rnd == 6'd63);
  assign take_byte  = (state == md5_pkg::ST_IDLE) && item_valid;

  always_comb begin
    state_next = state;
    unique case (state)
      md5_pkg::ST_IDLE: begin
        if (item_valid) begin
          if (item.has_byte && byte_position == 6'd63) begin
            state_next = md5_pkg::ST_ROUND;
          end else if (item.end_of_message) begin
            state_next = md5_pkg::ST_PAD;
          end
        end
      end
      md5_pkg::ST_PAD: begin
        if (byte_position == 6'd63) begin
          state_next = md5_pkg::ST_ROUND;
        end
      end
      md5_pkg::ST_ROUND: begin
        if (round_last) begin
          state_next = md5_pkg::ST_FINAL;
        end
      end
      md5_pkg::ST_FINAL: begin
        if (!after_pad) begin
          state_next = md5_pkg::ST_IDLE;
        end else if (pad_first || extra_block) begin
          state_next = md5_pkg::ST_PAD;
        end else begin
          state_next = md5_pkg::ST_EMIT;
        end
      end
      md5_pkg::ST_EMIT: begin
        if (out_ready && emit_index == 2'd3) begin
          state_next = md5_pkg::ST_IDLE;
        end
      end
      default: state_next = md5_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    item_pop  = take_byte;
    out_valid = (state == md5_pkg::ST_EMIT);
    unique case (emit_index)
      2'd0:    out_word = ca;
      2'd1:    out_word = cb;
      2'd2:    out_word = cc;
      default: out_word = cd;
    endcase
    out_index = emit_index;
    out_last  = (emit_index == 2'd3);
  end

  always_ff @(posedge clk) begin
    if (take_byte && item.has_byte) begin
      buffer[byte_position[5:2]][8*byte_position[1:0] +: 8] <= item.data_byte;
    end else if (state == md5_pkg::ST_PAD) begin
      buffer[byte_position[5:2]][8*byte_position[1:0] +: 8] <= pad_byte;
    end
    wreg <= buffer[g];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= md5_pkg::ST_IDLE;
      byte_position <= '0;
      bit_count     <= '0;
      len           <= '0;
      ca <= md5_pkg::InitA; cb <= md5_pkg::InitB;
      cc <= md5_pkg::InitC; cd <= md5_pkg::InitD;
      a <= '0; b <= '0; c <= '0; d <= '0;
      rnd           <= '0;
      emit_index    <= '0;
      pad_first     <= 1'b0;
      after_pad     <= 1'b0;
      extra_block   <= 1'b0;
    end else begin
      state <= state_next;
      unique case (state)
        md5_pkg::ST_IDLE: begin
          if (item_valid) begin
            if (item.has_byte) begin
              byte_position <= byte_position + 1'b1;
              bit_count     <= bit_count + 64'd8;
              len           <= bit_count + 64'd8;
            end else begin
              len <= bit_count;
            end
            pad_first <= item.end_of_message;
            after_pad <= item.end_of_message;
            rnd       <= '0;
            a <= ca; b <= cb; c <= cc; d <= cd;
          end
        end
        md5_pkg::ST_PAD: begin
          byte_position <= byte_position + 1'b1;
          pad_first     <= 1'b0;
          if (pad_first && byte_position >= 6'd56) begin
            extra_block <= 1'b1;
          end
          if (byte_position == 6'd63) begin
            rnd <= '0;
            a <= ca; b <= cb; c <= cc; d <= cd;
          end
        end
        md5_pkg::ST_ROUND: begin
          a   <= d;
          b   <= b + rot;
          c   <= b;
          d   <= c;
          rnd <= rnd + 1'b1;
        end
        md5_pkg::ST_FINAL: begin
          ca <= ca + a; cb <= cb + b; cc <= cc + c; cd <= cd + d;
          emit_index  <= '0;
          extra_block <= 1'b0;
        end
        md5_pkg::ST_EMIT: begin
          if (out_ready) begin
            emit_index <= emit_index + 1'b1;
            if (emit_index == 2'd3) begin
              ca <= md5_pkg::InitA; cb <= md5_pkg::InitB;
              cc <= md5_pkg::InitC; cd <= md5_pkg::InitD;
              byte_position <= '0;
              bit_count     <= '0;
              after_pad     <= 1'b0;
            end
          end
        end
        default: ;
      endcase
    end
  end
endmodule
`default_nettype wire

>>> src/md5_checker.sv
// Port checker for the MD5 digest engine and its binding.
`default_nettype none
`include "md5_message_digest_defines.svh"
module md5_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [1:0]  m_axis_tuser,
  input wire logic        m_axis_tlast
);
  `MD5_ASSERT_NOW(a_last_index, m_axis_tvalid, m_axis_tlast == (m_axis_tuser == 2'd3))
  `MD5_ASSERT_NEXT(a_index_step, m_axis_tvalid && m_axis_tready && !m_axis_tlast, m_axis_tvalid && m_axis_tuser == $past(m_axis_tuser) + 2'd1)
  `MD5_ASSERT_NEXT(a_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tuser))
endmodule

bind md5_message_digest md5_checker u_md5_checker (
  .clk, .rst, .m_axis_tvalid, .m_axis_tready, .m_axis_tuser, .m_axis_tlast
);
`default_nettype wire
